>>> hw/rtl/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared constants, types and codes of the braille text renderer.
// ----------------------------------------------------------------------------
package bbt_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int STORE_DEPTH = (MAX_WIDTH + 7) / 8;
    localparam int COL_W       = $clog2(STORE_DEPTH);
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int ENTRY_W     = 32;
    localparam int WBYTES_W    = COL_W + 1;
    localparam int REM_W       = WIDTH_W + 2;

    localparam logic [7:0] UTF8_LEAD   = 8'hE2;
    localparam logic [7:0] UTF8_MID    = 8'hA0;
    localparam logic [7:0] UTF8_TAIL   = 8'h80;
    localparam logic [7:0] NEWLINE     = 8'h0A;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } bbt_reg_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic [2:0]         cells;
        logic               newline;
        logic               end_of_image;
    } bbt_job_t;

endpackage

>>> hw/rtl/bbt_raster_if.sv
// ----------------------------------------------------------------------------
// bbt_raster_if
// Channel that carries packed raster bytes into the renderer.
// ----------------------------------------------------------------------------
interface bbt_raster_if;

    logic       valid;
    logic       ready;
    logic [7:0] raster_byte;

    modport source (output valid, output raster_byte, input ready);
    modport sink (input valid, input raster_byte, output ready);

endinterface

>>> hw/rtl/bbt_text_if.sv
// ----------------------------------------------------------------------------
// bbt_text_if
// Channel that carries UTF-8 braille text bytes out of the renderer.
// ----------------------------------------------------------------------------
interface bbt_text_if;

    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_in_run;
    logic       end_of_image;

    modport source (output valid, output text_byte, output last_in_run,
                    output end_of_image, input ready);
    modport sink (input valid, input text_byte, input last_in_run,
                  input end_of_image, output ready);

endinterface

>>> hw/rtl/bbt_cell_store.sv
// ----------------------------------------------------------------------------
// bbt_cell_store
// Line store of braille cells, one entry per byte column, registered read.
// ----------------------------------------------------------------------------
module bbt_cell_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [bbt_pkg::COL_W-1:0]   wr_addr,
    input  logic [bbt_pkg::ENTRY_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [bbt_pkg::COL_W-1:0]   rd_addr,
    output logic [bbt_pkg::ENTRY_W-1:0] rd_data
);

    logic [bbt_pkg::ENTRY_W-1:0] mem [bbt_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/bbt_cell_merge.sv
// ----------------------------------------------------------------------------
// bbt_cell_merge
// Tracks the raster position, folds each byte into the stored cells of its
// column by read, modify and write, and hands finished cells to the emitter.
// ----------------------------------------------------------------------------
module bbt_cell_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    bbt_raster_if.sink                    raster,
    input  logic [bbt_pkg::WIDTH_W-1:0]   image_width,
    input  logic [bbt_pkg::HEIGHT_W-1:0]  image_height,
    output logic                          mem_wr_en,
    output logic [bbt_pkg::COL_W-1:0]     mem_wr_addr,
    output logic [bbt_pkg::ENTRY_W-1:0]   mem_wr_data,
    output logic                          mem_rd_en,
    output logic [bbt_pkg::COL_W-1:0]     mem_rd_addr,
    input  logic [bbt_pkg::ENTRY_W-1:0]   mem_rd_data,
    output logic                          job_valid,
    input  logic                          job_ready,
    output bbt_pkg::bbt_job_t             job
);

    logic [bbt_pkg::COL_W-1:0]    byte_column_reg;
    logic [bbt_pkg::HEIGHT_W-1:0] pixel_row_reg;

    logic                         a_valid_reg;
    logic                         a_active_reg;
    logic                         a_job_reg;
    logic [7:0]                   a_px_reg;
    logic [7:0]                   a_mask_reg;
    logic [1:0]                   a_posy_reg;
    logic [bbt_pkg::COL_W-1:0]    a_col_reg;
    logic [2:0]                   a_cells_reg;
    logic                         a_newline_reg;
    logic                         a_eoi_reg;
    logic                         fwd_reg;
    logic [bbt_pkg::ENTRY_W-1:0]  fwd_data_reg;

    logic [bbt_pkg::WIDTH_W-1:0]  w_eff;
    logic [bbt_pkg::HEIGHT_W-1:0] h_eff;
    logic [bbt_pkg::WBYTES_W-1:0] wbytes;
    logic                         dropped;
    logic                         last_col;
    logic                         last_row;
    logic [1:0]                   posy;
    logic                         emit;
    logic signed [bbt_pkg::REM_W-1:0] rem;
    logic [7:0]                   mask;
    logic [2:0]                   cells;
    logic                         newline;
    logic                         accept;
    logic                         a_adv;
    logic [bbt_pkg::ENTRY_W-1:0]  entry_base;
    logic [bbt_pkg::ENTRY_W-1:0]  entry_new;

    always_comb
    begin
        if (image_width == '0)
        begin
            w_eff = bbt_pkg::WIDTH_W'(1);
        end
        else if (image_width > bbt_pkg::WIDTH_W'(bbt_pkg::MAX_WIDTH))
        begin
            w_eff = bbt_pkg::WIDTH_W'(bbt_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = image_width;
        end
        h_eff = (image_height == '0) ? bbt_pkg::HEIGHT_W'(1) : image_height;
    end

    always_comb
    begin
        wbytes   = bbt_pkg::WBYTES_W'(({1'b0, w_eff} + 13'd7) >> 3);
        dropped  = pixel_row_reg >= h_eff;
        last_col = ({1'b0, byte_column_reg} + bbt_pkg::WBYTES_W'(1)) >= wbytes;
        last_row = ({1'b0, pixel_row_reg} + 17'd1) >= {1'b0, h_eff};
        posy     = pixel_row_reg[1:0];
        emit     = (posy == 2'd3) || last_row;
        rem      = $signed(bbt_pkg::REM_W'(w_eff))
                 - $signed(bbt_pkg::REM_W'({byte_column_reg, 3'b000}));
        for (int p = 0; p < 8; p++)
        begin
            mask[p] = rem > $signed(bbt_pkg::REM_W'(p));
        end
        if (!emit || rem <= 0)
        begin
            cells = 3'd0;
        end
        else if (rem > 6)
        begin
            cells = 3'd4;
        end
        else
        begin
            cells = 3'((rem + 1) >>> 1);
        end
        newline = emit && last_col && !last_row;
    end

    assign accept       = raster.valid && raster.ready;
    assign a_adv        = a_valid_reg && (!a_job_reg || job_ready);
    assign raster.ready = !a_valid_reg || a_adv;

    always_comb
    begin
        logic [2:0] dot;
        logic [4:0] pos;
        entry_base = (a_posy_reg == 2'd0) ? '0 : (fwd_reg ? fwd_data_reg : mem_rd_data);
        entry_new  = entry_base;
        for (int p = 0; p < 8; p++)
        begin
            if (a_posy_reg != 2'd3)
            begin
                dot = 3'(a_posy_reg) + (p[0] ? 3'd3 : 3'd0);
            end
            else
            begin
                dot = p[0] ? 3'd7 : 3'd6;
            end
            pos = 5'((p >> 1) * 8) + 5'(dot);
            if (a_px_reg[7 - p] && a_mask_reg[p])
            begin
                entry_new[pos] = 1'b1;
            end
        end
    end

    assign mem_wr_en   = a_adv && a_active_reg;
    assign mem_wr_addr = a_col_reg;
    assign mem_wr_data = entry_new;
    assign mem_rd_en   = accept;
    assign mem_rd_addr = byte_column_reg;

    assign job_valid        = a_valid_reg && a_job_reg;
    assign job.entry        = entry_new;
    assign job.cells        = a_cells_reg;
    assign job.newline      = a_newline_reg;
    assign job.end_of_image = a_eoi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_column_reg <= '0;
            pixel_row_reg   <= '0;
            a_valid_reg     <= 1'b0;
            a_active_reg    <= 1'b0;
            a_job_reg       <= 1'b0;
            fwd_reg         <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg  <= 1'b1;
                a_active_reg <= !dropped;
                a_job_reg    <= !dropped && (cells != 3'd0 || newline);
                fwd_reg      <= a_adv && a_active_reg && (a_col_reg == byte_column_reg);
                if (!dropped)
                begin
                    if (last_col)
                    begin
                        byte_column_reg <= '0;
                        pixel_row_reg   <= pixel_row_reg + 1'b1;
                    end
                    else
                    begin
                        byte_column_reg <= byte_column_reg + 1'b1;
                    end
                end
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_px_reg      <= raster.raster_byte;
            a_mask_reg    <= mask;
            a_posy_reg    <= posy;
            a_col_reg     <= byte_column_reg;
            a_cells_reg   <= cells;
            a_newline_reg <= newline;
            a_eoi_reg     <= last_col && last_row && (cells != 3'd0);
            fwd_data_reg  <= entry_new;
        end
    end

endmodule

>>> hw/rtl/bbt_text_emit.sv
// ----------------------------------------------------------------------------
// bbt_text_emit
// Serialises finished cells into UTF-8 bytes, plus a newline if the job asks,
// one byte per cycle while the text side is ready, via a registered output stage.
// ----------------------------------------------------------------------------
module bbt_text_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  bbt_pkg::bbt_job_t job,
    bbt_text_if.source        text
);

    bbt_pkg::bbt_job_t job_reg;
    logic              job_valid_reg;
    logic [2:0]        cell_reg;
    logic [1:0]        phase_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_eoi_reg;

    logic              load;
    logic              is_nl;
    logic              is_last;
    logic [7:0]        dots;
    logic [7:0]        byte_next;

    always_comb
    begin
        load    = job_valid_reg && (!out_valid_reg || text.ready);
        is_nl   = cell_reg == job_reg.cells;
        dots    = job_reg.entry[{cell_reg[1:0], 3'b000} +: 8];
        if (job_reg.newline)
        begin
            is_last = is_nl;
        end
        else
        begin
            is_last = (cell_reg == job_reg.cells - 3'd1) && (phase_reg == 2'd2);
        end
        if (is_nl)
        begin
            byte_next = bbt_pkg::NEWLINE;
        end
        else
        begin
            case (phase_reg)
                2'd0:    byte_next = bbt_pkg::UTF8_LEAD;
                2'd1:    byte_next = bbt_pkg::UTF8_MID | {6'd0, dots[7:6]};
                2'd2:    byte_next = bbt_pkg::UTF8_TAIL | {2'd0, dots[5:0]};
                default: byte_next = bbt_pkg::UTF8_LEAD;
            endcase
        end
        job_ready = !job_valid_reg || (load && is_last);
    end

    assign text.valid        = out_valid_reg;
    assign text.text_byte    = out_byte_reg;
    assign text.last_in_run  = out_last_reg;
    assign text.end_of_image = out_eoi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cell_reg      <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (job_valid && job_ready)
            begin
                job_valid_reg <= 1'b1;
                cell_reg      <= '0;
                phase_reg     <= '0;
            end
            else if (load)
            begin
                if (is_last)
                begin
                    job_valid_reg <= 1'b0;
                end
                else if (phase_reg == 2'd2)
                begin
                    phase_reg <= '0;
                    cell_reg  <= cell_reg + 3'd1;
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            job_reg <= job;
        end
        if (load)
        begin
            out_byte_reg <= byte_next;
            out_last_reg <= is_last;
            out_eoi_reg  <= is_last && job_reg.end_of_image;
        end
    end

endmodule

>>> hw/rtl/bitmap_to_braille_text.sv
// ----------------------------------------------------------------------------
// bitmap_to_braille_text
// Renders a packed 1-bit raster as UTF-8 braille text, one cell per 2x4 block.
// ----------------------------------------------------------------------------
// A raster byte is taken in every cycle while the text side keeps up. Bytes of
// the first three rows of a band produce no text and never stall the input; a
// byte of a band's last row, or of the image's last row, produces up to thirteen
// text bytes (three per finished cell and a newline at the end of a band); the
// emitter sends one byte per cycle while the text side is ready, and such a byte
// holds the input until the emitter takes its cells. The cell line store is a
// single-port-read memory with a registered read; no clearing pass after reset.
// Configuration must be written while the block is idle; it is not enforced.
module bitmap_to_braille_text (
    input  logic                            clk,
    input  logic                            rst_n,
    bbt_raster_if.sink                      raster,
    bbt_text_if.source                      text,
    input  logic                            cfg_write_en,
    input  logic [0:0]                      cfg_index,
    input  logic [bbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [bbt_pkg::WIDTH_W-1:0]  image_width_reg;
    logic [bbt_pkg::HEIGHT_W-1:0] image_height_reg;

    logic                         mem_wr_en;
    logic [bbt_pkg::COL_W-1:0]    mem_wr_addr;
    logic [bbt_pkg::ENTRY_W-1:0]  mem_wr_data;
    logic                         mem_rd_en;
    logic [bbt_pkg::COL_W-1:0]    mem_rd_addr;
    logic [bbt_pkg::ENTRY_W-1:0]  mem_rd_data;
    logic                         job_valid;
    logic                         job_ready;
    bbt_pkg::bbt_job_t            job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bbt_pkg::WIDTH_W'(8);
            image_height_reg <= bbt_pkg::HEIGHT_W'(4);
        end
        else if (cfg_write_en)
        begin
            case (bbt_pkg::bbt_reg_t'(cfg_index))
                bbt_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[bbt_pkg::WIDTH_W-1:0];
                bbt_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[bbt_pkg::HEIGHT_W-1:0];
                default:
                    image_width_reg <= image_width_reg;
            endcase
        end
    end

    bbt_cell_store u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bbt_cell_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .raster       (raster),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    bbt_text_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .text      (text)
    );

endmodule
